/* rtl/core/gdfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared types, codes and defaults for the graph DFS preorder unit.
// ----------------------------------------------------------------------------
package gdfs_pkg;

	// Fixed field widths
	localparam int NODE_W      = 6;
	localparam int CFG_W       = 7;
	localparam int OP_W        = 2;
	localparam int STAT_W      = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_TDATA_W = 8;

	// Default sizing
	localparam int DEF_MAX_NODES  = 64;
	localparam int DEF_MAX_DEGREE = 8;

	// Command codes carried in s_tuser
	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_RUN   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// Result status codes carried in m_tuser
	localparam logic [STAT_W-1:0] RES_OK    = 2'd0;
	localparam logic [STAT_W-1:0] RES_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] RES_RANGE = 2'd2;
	localparam logic [STAT_W-1:0] RES_ACK   = 2'd3;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LD_CHK,
		ST_ACK,
		ST_ROOT,
		ST_TOP_DEG,
		ST_STEP,
		ST_NBR,
		ST_POP_RD
	} state_t;

	// What goes into the output register
	typedef enum logic [2:0] {
		RK_ROOT,
		RK_NBR,
		RK_RANGE,
		RK_FULL,
		RK_ACK
	} res_kind_t;

	// Controller -> datapath
	typedef struct packed {
		logic      capture_in;  // latch edge, read degree of its source
		logic      clr_deg;     // drop all degrees
		logic      ld_commit;   // store edge, bump degree
		logic      trav_start;  // clear visited marks and counters
		logic      root_next;   // advance root scan
		logic      root_push;   // start a tree at the root
		logic      latch_deg;   // take degree of the new top
		logic      adj_rd;      // fetch next neighbor of the top
		logic      nbr_push;    // descend into the fetched neighbor
		logic      pop;         // leave the top level
		logic      pop_load;    // restore the top from the stack
		logic      emit;        // load a result beat
		res_kind_t emit_kind;
	} dp_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic out_free;
		logic range_bad;
		logic deg_full;
		logic root_done;
		logic root_visited;
		logic slot_more;
		logic depth_one;
		logic nbr_new;
		logic last_emit;
	} dp_stat_t;

endpackage

/* rtl/core/graph_dfs_preorder_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_dfs_preorder_unit
// Directed-graph depth-first search engine with preorder output.
// ----------------------------------------------------------------------------
// Commands arrive as input beats: add edge (src, dst appended to the source's
// adjacency list, up to MAX_DEGREE per node), run traversal, clear graph.
// An edge load or a clear returns one status beat. A traversal returns
// node_count beats in preorder, roots in ascending order, the last one
// flagged with tlast. A traversal scans the roots, reads each adjacency slot
// (adjacency memory read, then check), reads the degree memory on each
// descent and the stack memory on each return; these single-port memory reads
// set the pace. One command is in work at a time; a result beat may still
// wait in the output register while the next command is accepted. node_count
// is to be written through the cfg port only while no command is in work; the
// block itself does not enforce it. node_count saturates to 1..MAX_NODES.
module graph_dfs_preorder_unit #(
	parameter int MAX_NODES  = gdfs_pkg::DEF_MAX_NODES,
	parameter int MAX_DEGREE = gdfs_pkg::DEF_MAX_DEGREE
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// node_count register write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [gdfs_pkg::CFG_W-1:0]       cfg_data,
	// command beats
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gdfs_pkg::IN_TDATA_W-1:0]  s_tdata,  // [5:0] src_node, [11:6] dst_node
	input  logic [gdfs_pkg::OP_W-1:0]        s_tuser,  // [1:0] op
	// result beats
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [gdfs_pkg::OUT_TDATA_W-1:0] m_tdata,  // [5:0] node_index
	output logic [gdfs_pkg::STAT_W-1:0]      m_tuser,  // [1:0] status
	output logic                             m_tlast
);
	import gdfs_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	gdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_op    (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	gdfs_dp #(
		.MAX_NODES  (MAX_NODES),
		.MAX_DEGREE (MAX_DEGREE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.in_src    (s_tdata[NODE_W-1:0]),
		.in_dst    (s_tdata[2*NODE_W-1:NODE_W]),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

/* rtl/core/gdfs_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer for edge loads, graph clears and the DFS walk.
// ----------------------------------------------------------------------------
module gdfs_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [gdfs_pkg::OP_W-1:0] in_op,
	output logic                    in_ready,
	input  gdfs_pkg::dp_stat_t      stat,
	output gdfs_pkg::dp_cmd_t       cmd
);
	import gdfs_pkg::*;

	state_t state_q, state_d;
	op_t    op;

	assign op = op_t'(in_op);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (op)
						OP_ADD:   state_d = ST_LD_CHK;
						OP_RUN:   state_d = ST_ROOT;
						OP_CLEAR: state_d = ST_ACK;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_LD_CHK, ST_ACK: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			ST_ROOT: begin
				if (stat.root_done) begin
					state_d = ST_IDLE;
				end else if (!stat.root_visited && stat.out_free) begin
					state_d = stat.last_emit ? ST_IDLE : ST_TOP_DEG;
				end
			end
			ST_TOP_DEG: state_d = ST_STEP;
			ST_STEP: begin
				if (stat.slot_more) begin
					state_d = ST_NBR;
				end else begin
					state_d = stat.depth_one ? ST_ROOT : ST_POP_RD;
				end
			end
			ST_NBR: begin
				if (!stat.nbr_new) begin
					state_d = ST_STEP;
				end else if (stat.out_free) begin
					state_d = stat.last_emit ? ST_IDLE : ST_TOP_DEG;
				end
			end
			ST_POP_RD: state_d = ST_STEP;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd       = '0;
		cmd.emit_kind = RK_ACK;
		in_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (op)
						OP_ADD:   cmd.capture_in = 1'b1;
						OP_RUN:   cmd.trav_start = 1'b1;
						OP_CLEAR: cmd.clr_deg    = 1'b1;
						default:  ;
					endcase
				end
			end
			ST_LD_CHK: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					if (stat.range_bad) begin
						cmd.emit_kind = RK_RANGE;
					end else if (stat.deg_full) begin
						cmd.emit_kind = RK_FULL;
					end else begin
						cmd.emit_kind = RK_ACK;
						cmd.ld_commit = 1'b1;
					end
				end
			end
			ST_ACK: begin
				if (stat.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = RK_ACK;
				end
			end
			ST_ROOT: begin
				if (!stat.root_done) begin
					if (stat.root_visited) begin
						cmd.root_next = 1'b1;
					end else if (stat.out_free) begin
						cmd.root_next = 1'b1;
						cmd.root_push = 1'b1;
						cmd.emit      = 1'b1;
						cmd.emit_kind = RK_ROOT;
					end
				end
			end
			ST_TOP_DEG: cmd.latch_deg = 1'b1;
			ST_STEP: begin
				if (stat.slot_more) begin
					cmd.adj_rd = 1'b1;
				end else begin
					cmd.pop = 1'b1;
				end
			end
			ST_NBR: begin
				if (stat.nbr_new && stat.out_free) begin
					cmd.nbr_push  = 1'b1;
					cmd.emit      = 1'b1;
					cmd.emit_kind = RK_NBR;
				end
			end
			ST_POP_RD: cmd.pop_load = 1'b1;
			default: ;
		endcase
	end

endmodule

/* rtl/core/gdfs_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_dp
// Graph storage, DFS stack, visited marks, config register and result beat.
// ----------------------------------------------------------------------------
module gdfs_dp #(
	parameter int MAX_NODES  = gdfs_pkg::DEF_MAX_NODES,
	parameter int MAX_DEGREE = gdfs_pkg::DEF_MAX_DEGREE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gdfs_pkg::dp_cmd_t                 cmd,
	output gdfs_pkg::dp_stat_t                stat,
	input  logic                              cfg_valid,
	input  logic [gdfs_pkg::CFG_W-1:0]        cfg_data,
	input  logic [gdfs_pkg::NODE_W-1:0]       in_src,
	input  logic [gdfs_pkg::NODE_W-1:0]       in_dst,
	input  logic                              m_tready,
	output logic                              m_tvalid,
	output logic [gdfs_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [gdfs_pkg::STAT_W-1:0]       m_tuser,
	output logic                              m_tlast
);
	import gdfs_pkg::*;

	localparam int NIW       = $clog2(MAX_NODES);
	localparam int NCW       = $clog2(MAX_NODES + 1);
	localparam int DW        = $clog2(MAX_DEGREE + 1);
	localparam int ADJ_DEPTH = MAX_NODES * MAX_DEGREE;
	localparam int AW        = $clog2(ADJ_DEPTH);

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [DW-1:0]     slot;
		logic [DW-1:0]     deg;
	} stk_ent_t;

	// Storage
	logic [NODE_W-1:0] adj_mem [ADJ_DEPTH];
	logic [DW-1:0]     deg_mem [MAX_NODES];
	stk_ent_t          stk_mem [MAX_NODES];

	logic [CFG_W-1:0]  node_count_q;
	logic [NODE_W-1:0] src_q, dst_q;
	logic [NODE_W-1:0] adj_rd_q;
	logic [DW-1:0]     deg_rd_q;
	logic              deg_hit_q;
	logic [MAX_NODES-1:0] deg_vld_q;
	logic [MAX_NODES-1:0] visited_q;
	logic [NCW-1:0]    root_q, emit_cnt_q, depth_q;
	logic [NODE_W-1:0] top_node_q;
	logic [DW-1:0]     top_slot_q, top_deg_q;
	stk_ent_t          stk_rd_q;
	logic              out_valid_q;
	logic [NODE_W-1:0] out_node_q;
	logic [STAT_W-1:0] out_stat_q;
	logic              out_last_q;

	logic [CFG_W-1:0]  cfg_sat;
	logic [DW-1:0]     deg_cur;
	logic [AW-1:0]     adj_wr_addr, adj_rd_addr;
	logic [NODE_W-1:0] deg_rd_node;
	logic              deg_rd_en;
	logic [NIW-1:0]    stk_wr_idx, stk_rd_idx;
	logic              last_emit;
	logic [NODE_W-1:0] emit_node;
	logic [STAT_W-1:0] emit_stat;
	logic              emit_last;

	// Config saturation to 1..MAX_NODES
	always_comb begin
		cfg_sat = cfg_data;
		if (cfg_data == '0) begin
			cfg_sat = CFG_W'(1);
		end else if (cfg_data > CFG_W'(MAX_NODES)) begin
			cfg_sat = CFG_W'(MAX_NODES);
		end
	end

	// Address and index generation
	assign deg_cur     = deg_hit_q ? deg_rd_q : '0;
	assign adj_wr_addr = AW'(src_q[NIW-1:0]) * AW'(MAX_DEGREE) + AW'(deg_cur);
	assign adj_rd_addr = AW'(top_node_q[NIW-1:0]) * AW'(MAX_DEGREE) + AW'(top_slot_q);
	assign stk_wr_idx  = NIW'(depth_q - NCW'(1));
	assign stk_rd_idx  = NIW'(depth_q - NCW'(2));
	assign deg_rd_en   = cmd.capture_in | cmd.root_push | cmd.nbr_push;

	always_comb begin
		deg_rd_node = adj_rd_q;
		if (cmd.capture_in) begin
			deg_rd_node = in_src;
		end else if (cmd.root_push) begin
			deg_rd_node = NODE_W'(root_q);
		end
	end

	// Status back to the controller
	assign last_emit = (CFG_W'(emit_cnt_q) + CFG_W'(1)) == node_count_q;

	always_comb begin
		stat              = '0;
		stat.out_free     = !out_valid_q || m_tready;
		stat.range_bad    = (CFG_W'(src_q) >= node_count_q) || (CFG_W'(dst_q) >= node_count_q);
		stat.deg_full     = deg_cur >= DW'(MAX_DEGREE);
		stat.root_done    = CFG_W'(root_q) >= node_count_q;
		stat.root_visited = stat.root_done ? 1'b1 : visited_q[root_q[NIW-1:0]];
		stat.slot_more    = top_slot_q < top_deg_q;
		stat.depth_one    = depth_q == NCW'(1);
		stat.nbr_new      = (CFG_W'(adj_rd_q) < node_count_q) && !visited_q[adj_rd_q[NIW-1:0]];
		stat.last_emit    = last_emit;
	end

	// Result beat contents
	always_comb begin
		emit_node = '0;
		emit_stat = RES_ACK;
		emit_last = 1'b1;
		case (cmd.emit_kind)
			RK_ROOT: begin
				emit_node = NODE_W'(root_q);
				emit_stat = RES_OK;
				emit_last = last_emit;
			end
			RK_NBR: begin
				emit_node = adj_rd_q;
				emit_stat = RES_OK;
				emit_last = last_emit;
			end
			RK_RANGE: emit_stat = RES_RANGE;
			RK_FULL:  emit_stat = RES_FULL;
			RK_ACK:   emit_stat = RES_ACK;
			default:  emit_stat = RES_ACK;
		endcase
	end

	// Adjacency memory
	always_ff @(posedge clk) begin
		if (cmd.ld_commit) begin
			adj_mem[adj_wr_addr] <= dst_q;
		end
		if (cmd.adj_rd) begin
			adj_rd_q <= adj_mem[adj_rd_addr];
		end
	end

	// Degree memory
	always_ff @(posedge clk) begin
		if (cmd.ld_commit) begin
			deg_mem[src_q[NIW-1:0]] <= deg_cur + DW'(1);
		end
		if (deg_rd_en) begin
			deg_rd_q <= deg_mem[deg_rd_node[NIW-1:0]];
		end
	end

	// Stack memory
	always_ff @(posedge clk) begin
		if (cmd.nbr_push) begin
			stk_mem[stk_wr_idx] <= '{node: top_node_q, slot: top_slot_q, deg: top_deg_q};
		end
		if (cmd.pop) begin
			stk_rd_q <= stk_mem[stk_rd_idx];
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			src_q <= in_src;
			dst_q <= in_dst;
		end
		if (cmd.root_push) begin
			top_node_q <= NODE_W'(root_q);
			top_slot_q <= '0;
		end else if (cmd.nbr_push) begin
			top_node_q <= adj_rd_q;
			top_slot_q <= '0;
		end else if (cmd.adj_rd) begin
			top_slot_q <= top_slot_q + DW'(1);
		end else if (cmd.pop_load) begin
			top_node_q <= stk_rd_q.node;
			top_slot_q <= stk_rd_q.slot;
		end
		if (cmd.latch_deg) begin
			top_deg_q <= deg_cur;
		end else if (cmd.pop_load) begin
			top_deg_q <= stk_rd_q.deg;
		end
		if (cmd.emit) begin
			out_node_q <= emit_node;
			out_stat_q <= emit_stat;
			out_last_q <= emit_last;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CFG_W'(MAX_NODES);
			deg_vld_q    <= '0;
			deg_hit_q    <= 1'b0;
			visited_q    <= '0;
			root_q       <= '0;
			emit_cnt_q   <= '0;
			depth_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				node_count_q <= cfg_sat;
			end
			// degree valid bits: an invalid entry reads as zero
			if (cmd.clr_deg) begin
				deg_vld_q <= '0;
			end else if (cmd.ld_commit) begin
				deg_vld_q[src_q[NIW-1:0]] <= 1'b1;
			end
			if (deg_rd_en) begin
				deg_hit_q <= deg_vld_q[deg_rd_node[NIW-1:0]];
			end
			// visited marks and walk counters
			if (cmd.trav_start) begin
				visited_q  <= '0;
				root_q     <= '0;
				emit_cnt_q <= '0;
				depth_q    <= '0;
			end else begin
				if (cmd.root_push) begin
					visited_q[root_q[NIW-1:0]] <= 1'b1;
				end else if (cmd.nbr_push) begin
					visited_q[adj_rd_q[NIW-1:0]] <= 1'b1;
				end
				if (cmd.root_next) begin
					root_q <= root_q + NCW'(1);
				end
				if (cmd.root_push || cmd.nbr_push) begin
					emit_cnt_q <= emit_cnt_q + NCW'(1);
				end
				if (cmd.root_push) begin
					depth_q <= NCW'(1);
				end else if (cmd.nbr_push) begin
					depth_q <= depth_q + NCW'(1);
				end else if (cmd.pop) begin
					depth_q <= depth_q - NCW'(1);
				end
			end
			// output beat holding register
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_node_q);
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

endmodule

/* rtl/core/gdfs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdfs_checker
// Port-level checks for the graph DFS preorder unit, bound to the top level.
// ----------------------------------------------------------------------------
module gdfs_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             cfg_valid,
	input logic                             cfg_ready,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic [gdfs_pkg::OP_W-1:0]        s_tuser,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [gdfs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [gdfs_pkg::STAT_W-1:0]      m_tuser,
	input logic                             m_tlast
);
	import gdfs_pkg::*;

	// A stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result beat changed while stalled");

	// Status beats carry no node and always close their command
	a_status_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != RES_OK) |-> (m_tdata == '0) && m_tlast)
		else $error("status beat malformed");

	// Node index fits its field
	a_node_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[OUT_TDATA_W-1:NODE_W] == '0)
		else $error("node index padding not zero");

	// A command is not taken in the cycle after an add or clear is accepted
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && ((s_tuser == OP_ADD) || (s_tuser == OP_CLEAR)) |=> !s_tready)
		else $error("command accepted while previous one in work");

	// A config beat never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config beat stalled");

endmodule

bind graph_dfs_preorder_unit gdfs_checker u_gdfs_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for graph_dfs_preorder_unit. A short table of commands
// covers the corners (full lists, range errors, ignored codes, node_count
// saturation, stale edges). Random phases of edge loads, traversals and
// clears follow. Each accepted command runs through a mirror of the graph
// that queues the beats it must return; every result beat is matched in order.
// ----------------------------------------------------------------------------
module tb;
	import gdfs_pkg::*;

	localparam int NODES        = DEF_MAX_NODES;
	localparam int DEGREE       = DEF_MAX_DEGREE;
	localparam int SETTLE       = 1200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 245;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [STAT_W-1:0] status;
		logic              last;
	} beat_t;

	typedef struct packed {
		logic              is_cfg;
		logic [CFG_W-1:0]  cfg_val;
		op_t               op;
		logic [NODE_W-1:0] src;
		logic [NODE_W-1:0] dst;
		logic              typed;
		logic [STAT_W-1:0] typed_status;
	} plan_row_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_W-1:0]       cfg_data  = '0;
	logic                   s_tvalid  = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [OP_W-1:0]        s_tuser   = '0;
	logic                   m_tready  = 1'b0;
	logic                   cfg_ready;
	logic                   s_tready;
	logic                   m_tvalid;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]      m_tuser;
	logic                   m_tlast;

	graph_dfs_preorder_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Mirror of the graph and of node_count
	int unsigned       live_nodes;
	logic [NODE_W-1:0] adj_mirror [NODES*DEGREE];
	int unsigned       deg_mirror [NODES];

	beat_t       fresh_beats [$];   // beats of the command just accepted
	beat_t       pending_beats [$]; // beats still owed by the block
	plan_row_t   plan [$];          // directed stimulus table
	int          fault_count = 0;
	bit          calm        = 1'b0;
	int unsigned cycle_count = 0;

	always #4 clk = ~clk;

	function automatic beat_t make_beat(logic [NODE_W-1:0] node, logic [STAT_W-1:0] status,
			logic last);
		beat_t b;
		b.node   = node;
		b.status = status;
		b.last   = last;
		return b;
	endfunction

	// Append to the beat queues
	function automatic void queue_fresh(beat_t b);
		fresh_beats = {fresh_beats, b};
	endfunction

	function automatic void queue_owed(beat_t b);
		pending_beats = {pending_beats, b};
	endfunction

	task automatic note_fault(string msg);
		$display("tb: mismatch at cycle %0d: %s", cycle_count, msg);
		fault_count++;
	endtask

	function automatic void set_live_nodes(logic [CFG_W-1:0] v);
		if (v == 0)
			live_nodes = 1;
		else if (v > NODES)
			live_nodes = NODES;
		else
			live_nodes = v;
	endfunction

	// Mirror one command: update the graph and fill fresh_beats
	function automatic void predict_command(op_t op, logic [NODE_W-1:0] src,
			logic [NODE_W-1:0] dst);
		bit          seen [NODES];
		int unsigned stk_node [NODES];
		int unsigned stk_slot [NODES];
		int unsigned depth;
		int unsigned emitted;
		int unsigned cur;
		int unsigned nb;
		fresh_beats.delete();
		case (op)
			OP_ADD: begin
				if (src >= live_nodes || dst >= live_nodes) begin
					queue_fresh(make_beat('0, RES_RANGE, 1'b1));
				end else if (deg_mirror[src] >= DEGREE) begin
					queue_fresh(make_beat('0, RES_FULL, 1'b1));
				end else begin
					adj_mirror[src*DEGREE + deg_mirror[src]] = dst;
					deg_mirror[src]++;
					queue_fresh(make_beat('0, RES_ACK, 1'b1));
				end
			end
			OP_RUN: begin
				foreach (seen[i])
					seen[i] = 1'b0;
				emitted = 0;
				for (int r = 0; r < live_nodes; r++) begin
					if (!seen[r]) begin
						seen[r] = 1'b1;
						emitted++;
						queue_fresh(make_beat(NODE_W'(r), RES_OK, emitted == live_nodes));
						stk_node[0] = r;
						stk_slot[0] = 0;
						depth = 1;
						// walk down the tree, one adjacency slot at a time
						while (depth > 0) begin
							cur = stk_node[depth-1];
							if (stk_slot[depth-1] < deg_mirror[cur]) begin
								nb = adj_mirror[cur*DEGREE + stk_slot[depth-1]];
								stk_slot[depth-1]++;
								// stale edges past node_count are skipped
								if (nb < live_nodes && !seen[nb] && depth < NODES) begin
									seen[nb] = 1'b1;
									emitted++;
									queue_fresh(make_beat(NODE_W'(nb), RES_OK,
										emitted == live_nodes));
									stk_node[depth] = nb;
									stk_slot[depth] = 0;
									depth++;
								end
							end else begin
								depth--;
							end
						end
					end
				end
			end
			OP_CLEAR: begin
				foreach (deg_mirror[i])
					deg_mirror[i] = 0;
				queue_fresh(make_beat('0, RES_ACK, 1'b1));
			end
			default: begin
				// reserved code: no beat, no change
			end
		endcase
	endfunction

	// Send one command beat, with a random gap ahead of it
	task automatic send_command(op_t op, logic [NODE_W-1:0] src, logic [NODE_W-1:0] dst,
			logic typed, logic [STAT_W-1:0] typed_status);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < 10)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'b0, dst, src};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_command(op, src, dst);
		if (typed)
			queue_owed(make_beat('0, typed_status, 1'b1));
		else
			foreach (fresh_beats[i])
				queue_owed(fresh_beats[i]);
	endtask

	// Hold off until every owed beat is back and the block has gone quiet
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_node_count(logic [CFG_W-1:0] v);
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		set_live_nodes(v);
	endtask

	function automatic plan_row_t cmd_row(op_t op, logic [NODE_W-1:0] src,
			logic [NODE_W-1:0] dst, logic typed, logic [STAT_W-1:0] typed_status);
		plan_row_t row;
		row              = '0;
		row.op           = op;
		row.src          = src;
		row.dst          = dst;
		row.typed        = typed;
		row.typed_status = typed_status;
		return row;
	endfunction

	function automatic plan_row_t cfg_row(logic [CFG_W-1:0] v);
		plan_row_t row;
		row         = '0;
		row.is_cfg  = 1'b1;
		row.cfg_val = v;
		return row;
	endfunction

	function automatic void add_row(plan_row_t row);
		plan = {plan, row};
	endfunction

	// Result side: random stalls, none during the calm stretch
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 10);

	// Match each result beat against the oldest owed beat
	always @(posedge clk) begin
		beat_t got;
		beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = make_beat(m_tdata[NODE_W-1:0], m_tuser, m_tlast);
			if (pending_beats.size() == 0) begin
				note_fault($sformatf("unexpected beat node %0d status %0d last %0d",
					got.node, got.status, got.last));
			end else begin
				want = pending_beats.pop_front();
				if (got !== want)
					note_fault($sformatf("node %0d/%0d status %0d/%0d last %0d/%0d (got/want)",
						got.node, want.node, got.status, want.status, got.last, want.last));
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		int                done_items;
		int                phase_len;
		int                pick;
		logic [CFG_W-1:0]  nc_val;
		op_t               op;
		logic [NODE_W-1:0] src_pick;
		logic [NODE_W-1:0] dst_pick;

		live_nodes = NODES;
		foreach (deg_mirror[i])
			deg_mirror[i] = 0;
		foreach (adj_mirror[i])
			adj_mirror[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: node_count starts at 64
		add_row(cmd_row(OP_ADD, 6'd63, 6'd0, 1'b1, RES_ACK));
		add_row(cmd_row(OP_ADD, 6'd0, 6'd63, 1'b1, RES_ACK));
		add_row(cmd_row(OP_NONE, 6'd63, 6'd63, 1'b0, RES_OK));
		for (int k = 0; k < DEGREE; k++)
			add_row(cmd_row(OP_ADD, 6'd1, NODE_W'(k + 2), 1'b1, RES_ACK));
		add_row(cmd_row(OP_ADD, 6'd1, 6'd10, 1'b1, RES_FULL));
		add_row(cmd_row(OP_RUN, 6'd0, 6'd0, 1'b0, RES_OK));
		// zero saturates to one node
		add_row(cfg_row(7'd0));
		add_row(cmd_row(OP_ADD, 6'd0, 6'd0, 1'b1, RES_ACK));
		add_row(cmd_row(OP_ADD, 6'd1, 6'd0, 1'b1, RES_RANGE));
		add_row(cmd_row(OP_ADD, 6'd0, 6'd5, 1'b1, RES_RANGE));
		add_row(cmd_row(OP_RUN, 6'd0, 6'd0, 1'b0, RES_OK));
		// shrunk graph: edges into high nodes go stale
		add_row(cfg_row(7'd10));
		add_row(cmd_row(OP_RUN, 6'd0, 6'd0, 1'b0, RES_OK));
		// above the top saturates to 64
		add_row(cfg_row(7'd127));
		add_row(cmd_row(OP_RUN, 6'd0, 6'd0, 1'b0, RES_OK));
		add_row(cmd_row(OP_CLEAR, 6'd0, 6'd0, 1'b1, RES_ACK));
		add_row(cmd_row(OP_RUN, 6'd0, 6'd0, 1'b0, RES_OK));
		add_row(cmd_row(OP_ADD, 6'd63, 6'd63, 1'b1, RES_ACK));

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_node_count(plan[i].cfg_val);
			else
				send_command(plan[i].op, plan[i].src, plan[i].dst, plan[i].typed,
					plan[i].typed_status);
		end

		// Random phases: pick a size, load edges among other commands, traverse
		done_items = 0;
		while (done_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: nc_val = 7'd0;
				1: nc_val = 7'd64;
				2: nc_val = CFG_W'($urandom_range(65, 127));
				3: nc_val = CFG_W'($urandom_range(17, 63));
				default: nc_val = CFG_W'($urandom_range(1, 16));
			endcase
			write_node_count(nc_val);
			if ($urandom_range(0, 2) == 0) begin
				send_command(OP_CLEAR, NODE_W'($urandom), NODE_W'($urandom), 1'b0, RES_OK);
				done_items++;
			end
			phase_len = $urandom_range(8, 30);
			repeat (phase_len) begin
				calm     = (done_items >= 100 && done_items < 160);
				pick     = $urandom_range(0, 99);
				src_pick = NODE_W'($urandom_range(0, live_nodes - 1));
				dst_pick = NODE_W'($urandom_range(0, live_nodes - 1));
				if (pick < 62) begin
					op = OP_ADD;
				end else if (pick < 72) begin
					op       = OP_ADD;
					src_pick = NODE_W'($urandom);
					dst_pick = NODE_W'($urandom);
				end else if (pick < 84) begin
					op = OP_RUN;
				end else if (pick < 89) begin
					op = OP_CLEAR;
				end else if (pick < 94) begin
					op       = OP_NONE;
					src_pick = NODE_W'($urandom);
					dst_pick = NODE_W'($urandom);
				end else begin
					op       = OP_ADD;
					dst_pick = NODE_W'($urandom);
				end
				send_command(op, src_pick, dst_pick, 1'b0, RES_OK);
				if (op != OP_NONE)
					done_items++;
			end
			send_command(OP_RUN, NODE_W'($urandom), NODE_W'($urandom), 1'b0, RES_OK);
			done_items++;
		end
		calm = 1'b0;

		settle_idle();
		if (fault_count == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
